// ===== rtl/cpm_pkg.sv =====
`default_nettype none

package cpm_pkg;

  // Width of a coordinate difference and of its magnitude.
  localparam int unsigned DIFF_W = 33;
  // Width of a slope quotient before saturation.
  localparam int unsigned QUOT_W = 32;
  // Fraction bits of the Q16.16 format.
  localparam int unsigned FRAC_W = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ADAPTIVE = 2'd0;
  localparam logic [1:0] CFG_SLOPE_TOL = 2'd1;
  localparam logic [1:0] CFG_X_SHIFT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_XEQ1,
    S_XEQ2,
    S_SL1,
    S_W1,
    S_SL2,
    S_W2,
    S_CMP,
    S_DECIDE,
    S_EMITP,
    S_ADV,
    S_EMITL
  } state_e;

  // Request to the shared divider: magnitude of dy and of dx.
  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] num;
    logic [DIFF_W-1:0] den;
  } div_req_t;

  // Divider result: a one-cycle done pulse, an overflow flag for quotients of
  // 2^32 or more, and the quotient otherwise.
  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/collinear_point_merger.sv =====
// A point keeps the input stalled while it is checked, both without a slope
// (first points, vertical runs) and when two slopes are needed, and while a
// stalled output word holds back a vertex.
// Points are taken one at a time; two radix-2 divisions on one shared
// divider set the worst case.
// Reset clears the control, polyline and box registers and loads the defaults.
`default_nettype none

module collinear_point_merger #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Point input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic        ends_run_i,
  // Vertex output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] vertex_x_o,
  output logic [31:0] vertex_y_o,
  output logic        vertex_last_o,
  output logic [31:0] bound_min_x_o,
  output logic [31:0] bound_max_x_o,
  output logic [31:0] bound_min_y_o,
  output logic [31:0] bound_max_y_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i
);
  import cpm_pkg::*;

  // Only the low bits of a coordinate are significant, at most 32 of them.
  localparam int unsigned CoordW = (COORD_BITS > 32) ? 32 : COORD_BITS;

  // Configuration registers: write only while the block is idle; not enforced.
  logic        adaptive_q;
  logic [30:0] tol_q;
  logic [4:0]  xshift_q;

  // The sequencer walks one point through the checks. The divider is shared
  // by the two slope computations.
  state_e state_q, state_d;

  // The incoming point, sign extended from the coordinate width.
  logic signed [CoordW-1:0] in_x_c, in_y_c;
  logic signed [31:0]       in_x, in_y;
  logic signed [31:0]       new_x_q, new_x_d, new_y_q, new_y_d;
  logic                     last_q, last_d;

  // Polyline state: the committed vertex and the pending vertex.
  logic signed [31:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic signed [31:0] com_x_q, com_x_d, com_y_q, com_y_d;
  logic [1:0]         held_q, held_d;
  logic               merge_q, merge_d;
  logic               neg_q, neg_d;
  logic signed [31:0] s1_q, s1_d, s2_q, s2_d;

  // Bounding box.
  logic signed [31:0] bmin_x_q, bmin_x_d, bmax_x_q, bmax_x_d;
  logic signed [31:0] bmin_y_q, bmin_y_d, bmax_y_q, bmax_y_d;
  logic               box_valid_q, box_valid_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        load;
  logic [31:0] load_x, load_y;
  logic        load_last;
  logic        slot_free;
  logic [31:0] vx_q, vy_q, mnx_q, mxx_q, mny_q, mxy_q;
  logic        vlast_q;

  // Shared relative x-equality test: |a-b| << shift <= a+b, a+b not negative.
  // It is evaluated as |a-b| <= (a+b) >> shift, which is the same for
  // integers and keeps the shifter narrow.
  logic signed [31:0]       xeq_b;
  logic signed [DIFF_W-1:0] xeq_sum, xeq_dif;
  logic [DIFF_W-1:0]        xeq_mag, xeq_lim;
  logic                     xeq;

  // Shared difference unit for the slope operands.
  logic signed [31:0]       ya, yb, xa, xb;
  logic signed [DIFF_W-1:0] dy, dx;
  logic [DIFF_W-1:0]        dy_mag, dx_mag;

  // Slope difference against the tolerance.
  logic signed [DIFF_W-1:0] sdiff;
  logic [DIFF_W-1:0]        sdiff_mag;

  logic     in_fire;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Saturate a quotient magnitude into a signed slope.
  function automatic logic signed [31:0] sat_slope(input logic neg, input logic ovf,
                                                   input logic [QUOT_W-1:0] q);
    logic [QUOT_W-1:0] mag;
    begin
      if (neg) begin
        mag = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : q;
        sat_slope = -$signed(mag);
      end else begin
        mag = (ovf || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
        sat_slope = $signed(mag);
      end
    end
  endfunction

  cpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_x_c  = point_x_i[CoordW-1:0];
  assign in_y_c  = point_y_i[CoordW-1:0];
  assign in_x    = 32'(in_x_c);
  assign in_y    = 32'(in_y_c);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign xeq_b   = (state_q == S_XEQ2) ? com_x_q : new_x_q;
  assign xeq_sum = DIFF_W'(pend_x_q) + DIFF_W'(xeq_b);
  assign xeq_dif = DIFF_W'(pend_x_q) - DIFF_W'(xeq_b);
  assign xeq_mag = xeq_dif[DIFF_W-1] ? DIFF_W'(-xeq_dif) : DIFF_W'(xeq_dif);
  assign xeq_lim = DIFF_W'(xeq_sum) >> xshift_q;
  assign xeq     = !xeq_sum[DIFF_W-1] && (xeq_mag <= xeq_lim);

  // The first slope runs from the pending vertex to the new point, the second
  // from the committed vertex to the pending vertex.
  always_comb begin
    if (state_q == S_SL2) begin
      ya = pend_y_q;
      yb = com_y_q;
      xa = pend_x_q;
      xb = com_x_q;
    end else begin
      ya = new_y_q;
      yb = pend_y_q;
      xa = new_x_q;
      xb = pend_x_q;
    end
  end

  assign dy     = DIFF_W'(ya) - DIFF_W'(yb);
  assign dx     = DIFF_W'(xa) - DIFF_W'(xb);
  assign dy_mag = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign dx_mag = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);

  assign sdiff     = DIFF_W'(s2_q) - DIFF_W'(s1_q);
  assign sdiff_mag = sdiff[DIFF_W-1] ? DIFF_W'(-sdiff) : DIFF_W'(sdiff);

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    new_x_d     = new_x_q;
    new_y_d     = new_y_q;
    last_d      = last_q;
    pend_x_d    = pend_x_q;
    pend_y_d    = pend_y_q;
    com_x_d     = com_x_q;
    com_y_d     = com_y_q;
    held_d      = held_q;
    merge_d     = merge_q;
    neg_d       = neg_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    bmin_x_d    = bmin_x_q;
    bmax_x_d    = bmax_x_q;
    bmin_y_d    = bmin_y_q;
    bmax_y_d    = bmax_y_q;
    box_valid_d = box_valid_q;
    load        = 1'b0;
    load_x      = pend_x_q;
    load_y      = pend_y_q;
    load_last   = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = dy_mag;
    div_req.den   = dx_mag;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          new_x_d = in_x;
          new_y_d = in_y;
          last_d  = ends_run_i;
          // In adaptive mode the box is updated as the point arrives; results of
          // this point report the updated box.
          if (adaptive_q) begin
            if (!box_valid_q) begin
              bmin_x_d    = in_x;
              bmax_x_d    = in_x;
              bmin_y_d    = in_y;
              bmax_y_d    = in_y;
              box_valid_d = 1'b1;
            end else begin
              if (in_x < bmin_x_q) bmin_x_d = in_x;
              if (in_x > bmax_x_q) bmax_x_d = in_x;
              if (in_y < bmin_y_q) bmin_y_d = in_y;
              if (in_y > bmax_y_q) bmax_y_d = in_y;
            end
          end
          state_d = S_XEQ1;
        end
      end
      S_XEQ1: begin
        // With fewer than two points held there is nothing to merge with.
        if (held_q < 2'd2) begin
          merge_d = 1'b0;
          state_d = S_DECIDE;
        end else if (xeq) begin
          state_d = S_XEQ2;
        end else begin
          state_d = S_SL1;
        end
      end
      S_XEQ2: begin
        // A vertical run continues only if the pending vertex was on it too.
        merge_d = xeq;
        state_d = S_DECIDE;
      end
      S_SL1, S_SL2: begin
        // A zero x difference has no slope, and the merge fails.
        if (dx == '0) begin
          merge_d = 1'b0;
          state_d = S_DECIDE;
        end else begin
          div_req.start = 1'b1;
          neg_d   = dy[DIFF_W-1] ^ dx[DIFF_W-1];
          state_d = (state_q == S_SL1) ? S_W1 : S_W2;
        end
      end
      S_W1: begin
        if (div_rsp.done) begin
          s1_d    = sat_slope(neg_q, div_rsp.ovf, div_rsp.quot);
          state_d = S_SL2;
        end
      end
      S_W2: begin
        if (div_rsp.done) begin
          s2_d    = sat_slope(neg_q, div_rsp.ovf, div_rsp.quot);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        merge_d = (sdiff_mag <= DIFF_W'(tol_q));
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (held_q == 2'd0) begin
          held_d  = 2'd1;
          state_d = S_ADV;
        end else if (!merge_q) begin
          state_d = S_EMITP;
        end else begin
          state_d = S_ADV;
        end
      end
      S_EMITP: begin
        // The old pending vertex becomes final and is sent out.
        if (slot_free) begin
          load    = 1'b1;
          com_x_d = pend_x_q;
          com_y_d = pend_y_q;
          held_d  = 2'd2;
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        pend_x_d = new_x_q;
        pend_y_d = new_y_q;
        state_d  = last_q ? S_EMITL : S_IDLE;
      end
      S_EMITL: begin
        // End of the polyline: flush the pending vertex as the last one.
        if (slot_free) begin
          load      = 1'b1;
          load_last = 1'b1;
          held_d    = 2'd0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      adaptive_q  <= 1'b1;
      tol_q       <= 31'd655;
      xshift_q    <= 5'd20;
      held_q      <= 2'd0;
      pend_x_q    <= '0;
      pend_y_q    <= '0;
      com_x_q     <= '0;
      com_y_q     <= '0;
      bmin_x_q    <= '0;
      bmax_x_q    <= '0;
      bmin_y_q    <= '0;
      bmax_y_q    <= '0;
      box_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      pend_x_q    <= pend_x_d;
      pend_y_q    <= pend_y_d;
      com_x_q     <= com_x_d;
      com_y_q     <= com_y_d;
      bmin_x_q    <= bmin_x_d;
      bmax_x_q    <= bmax_x_d;
      bmin_y_q    <= bmin_y_d;
      bmax_y_q    <= bmax_y_d;
      box_valid_q <= box_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ADAPTIVE:  adaptive_q <= cfg_data_i[0];
          CFG_SLOPE_TOL: tol_q      <= cfg_data_i;
          CFG_X_SHIFT:   xshift_q   <= cfg_data_i[4:0];
          default:       ;
        endcase
      end
    end
  end

  // Working registers and the output word need no reset.
  always_ff @(posedge clk_i) begin
    new_x_q <= new_x_d;
    new_y_q <= new_y_d;
    last_q  <= last_d;
    merge_q <= merge_d;
    neg_q   <= neg_d;
    s1_q    <= s1_d;
    s2_q    <= s2_d;
    if (load) begin
      vx_q    <= load_x;
      vy_q    <= load_y;
      vlast_q <= load_last;
      mnx_q   <= bmin_x_q;
      mxx_q   <= bmax_x_q;
      mny_q   <= bmin_y_q;
      mxy_q   <= bmax_y_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vertex_x_o    = vx_q;
  assign vertex_y_o    = vy_q;
  assign vertex_last_o = vlast_q;
  assign bound_min_x_o = mnx_q;
  assign bound_max_x_o = mxx_q;
  assign bound_min_y_o = mny_q;
  assign bound_max_y_o = mxy_q;

endmodule

`default_nettype wire

// ===== rtl/cpm_div.sv =====
`default_nettype none

module cpm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpm_pkg::div_req_t req_i,
  output cpm_pkg::div_rsp_t rsp_o
);
  import cpm_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIFF_W-1:0] rem_q, rem_d;
  logic [DIFF_W-1:0] den_q, den_d;
  logic [QUOT_W-1:0] shf_q, shf_d;

  logic [DIFF_W:0]          trial;
  logic                     fits;
  logic                     too_big;

  // The quotient overflows 32 bits when num << 16 >= den << 32.
  assign too_big = {{FRAC_W{1'b0}}, req_i.num} >= {req_i.den, {FRAC_W{1'b0}}};
  assign trial   = {rem_q, shf_q[QUOT_W-1]};
  assign fits    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    shf_d  = shf_q;
    if (req_i.start) begin
      den_d = req_i.den;
      ovf_d = too_big;
      cnt_d = '0;
      if (too_big) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        // The upper part of num << 16 is already below den.
        rem_d  = DIFF_W'(req_i.num[DIFF_W-1:FRAC_W]);
        shf_d  = {req_i.num[FRAC_W-1:0], {(QUOT_W-FRAC_W){1'b0}}};
      end
    end else if (busy_q) begin
      rem_d = fits ? DIFF_W'(trial - {1'b0, den_q}) : DIFF_W'(trial);
      shf_d = {shf_q[QUOT_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    rem_q <= rem_d;
    den_q <= den_d;
    shf_q <= shf_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quot = shf_q;

endmodule

`default_nettype wire
